// ===== sv/msq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_pkg
// Shared widths, register indexes, configuration struct and scale tables
// for the musical scale quantizer.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int SEMITONES  = 12;
  localparam int NOTE_W     = 7;
  localparam int NOTE_OUT_W = 8;
  localparam int PC_W       = 4;
  localparam int OCT_W      = 4;
  localparam int ROOT_W     = 4;
  localparam int SCALE_W    = 3;
  localparam int NUM_SCALES = 8;
  localparam int DEG_N      = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_KEY     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 8'd1;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  root_key;      // always 0..11
    logic [SCALE_W-1:0] scale_select;
  } cfg_t;

  // scale degrees in semitones above the root; unused slots are zero
  localparam pc_t SCALE_ROWS [NUM_SCALES][DEG_N] = '{
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
    '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11}
  };

  localparam logic [PC_W-1:0] SCALE_LEN [NUM_SCALES] = '{
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd12
  };

endpackage

// ===== sv/msq_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_in_if
// Input note channel: valid/ready handshake carrying one MIDI note.
// ----------------------------------------------------------------------------
interface msq_in_if;
  import msq_pkg::*;

  logic              valid;
  logic              ready;
  logic [NOTE_W-1:0] note_in;

  modport source (output valid, output note_in, input ready);
  modport sink   (input valid, input note_in, output ready);
endinterface

// ===== sv/msq_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_out_if
// Result channel: valid/ready handshake carrying one quantized note.
// ----------------------------------------------------------------------------
interface msq_out_if;
  import msq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [NOTE_OUT_W-1:0] note_out;

  modport source (output valid, output note_out, input ready);
  modport sink   (input valid, input note_out, output ready);
endinterface

// ===== sv/msq_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface msq_cfg_if;
  import msq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/musical_scale_quantizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// musical_scale_quantizer
// Snaps MIDI notes to the nearest degree of a selected, transposed scale.
// ----------------------------------------------------------------------------
// One note per clock while out_chan.ready is high: the note is captured in an input
// register, quantized by one combinational pass (divide by 12, twelve
// candidate distances, minimum tree) and stored in the result register.
// The two registers form a two-stage pipeline, so a new note can still enter an empty
// input register while a finished result waits on out_chan.ready. Config writes are
// registered and take effect in the next cycle; cfg_chan.ready is always high.
module musical_scale_quantizer (
  input  logic      clk,
  input  logic      rst_n,
  msq_in_if.sink    in_chan,
  msq_out_if.source out_chan,
  msq_cfg_if.sink   cfg_chan
);
  import msq_pkg::*;

  cfg_t                  cfg;
  logic                  s1_valid_r;
  logic                  s1_valid_nxt;
  logic [NOTE_W-1:0]     s1_note_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [NOTE_OUT_W-1:0] out_note_r;
  logic [NOTE_OUT_W-1:0] note_q;
  logic                  s2_free;
  logic                  s1_free;
  logic                  in_take;
  logic                  s1_move;

  msq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  msq_nearest u_nearest (
    .cfg    (cfg),
    .note   (s1_note_r),
    .note_q (note_q)
  );

  assign s2_free = !out_valid_r || out_chan.ready;
  assign s1_move = s1_valid_r && s2_free;
  assign s1_free = !s1_valid_r || s2_free;
  assign in_take = in_chan.valid && s1_free;

  assign in_chan.ready = s1_free;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_move ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_note_r <= in_chan.note_in;
    end
    if (s1_move) begin
      out_note_r <= note_q;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.note_out = out_note_r;
endmodule

// ===== sv/msq_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_cfg_regs
// Root key and scale select registers. Root is taken from the low four data bits and reduced modulo 12 on write.
// ----------------------------------------------------------------------------
module msq_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  msq_cfg_if.sink       cfg_chan,
  output msq_pkg::cfg_t cfg
);
  import msq_pkg::*;

  cfg_t              cfg_r;
  cfg_t              cfg_nxt;
  logic [ROOT_W-1:0] root_raw;

  assign cfg_chan.ready = 1'b1;
  assign root_raw       = cfg_chan.data[ROOT_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_ROOT_KEY: begin
          cfg_nxt.root_key = (root_raw >= ROOT_W'(SEMITONES))
                             ? root_raw - ROOT_W'(SEMITONES) : root_raw;
        end
        REG_SCALE_SELECT: begin
          cfg_nxt.scale_select = cfg_chan.data[SCALE_W-1:0];
        end
        default: ;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

// ===== sv/msq_nearest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msq_nearest
// Combinational quantizer: splits the note into octave and pitch class,
// builds the transposed candidates and picks the nearest through a
// left-preferring minimum tree (ties keep the earlier degree).
// ----------------------------------------------------------------------------
module msq_nearest (
  input  msq_pkg::cfg_t                   cfg,
  input  logic [msq_pkg::NOTE_W-1:0]      note,
  output logic [msq_pkg::NOTE_OUT_W-1:0]  note_q
);
  import msq_pkg::*;

  localparam int           DIST_W  = 4;
  localparam int           PROD_W  = 13;
  localparam logic [5:0]   RECIP12 = 6'd43;  // floor(n*43/512) == n/12 for n < 128
  localparam int           RSHIFT  = 9;

  logic [PROD_W-1:0]     prod;
  logic [OCT_W-1:0]      oct;
  logic [NOTE_W-1:0]     oct_x12;
  logic [PC_W-1:0]       pc;
  logic [PC_W:0]         sum  [DEG_N];
  pc_t                   cand [DEG_N];
  logic [DIST_W-1:0]     gap  [DEG_N];
  pc_t                   l1_c [6];
  logic [DIST_W-1:0]     l1_d [6];
  pc_t                   l2_c [3];
  logic [DIST_W-1:0]     l2_d [3];
  pc_t                   l3_c;
  logic [DIST_W-1:0]     l3_d;
  pc_t                   best;

  assign prod    = PROD_W'(note) * PROD_W'(RECIP12);
  assign oct     = prod[RSHIFT +: OCT_W];
  assign oct_x12 = NOTE_W'({oct, 3'b000}) + NOTE_W'({oct, 2'b00});
  assign pc      = PC_W'(note - oct_x12);

  always_comb begin
    for (int i = 0; i < DEG_N; i++) begin
      sum[i]  = {1'b0, SCALE_ROWS[cfg.scale_select][i]} + {1'b0, cfg.root_key};
      cand[i] = (sum[i] >= (PC_W+1)'(SEMITONES)) ? PC_W'(sum[i] - (PC_W+1)'(SEMITONES))
                                                 : sum[i][PC_W-1:0];
      if (PC_W'(i) >= SCALE_LEN[cfg.scale_select]) begin
        gap[i] = '1;  // beyond the scale: never beats a real degree
      end else begin
        gap[i] = (cand[i] > pc) ? cand[i] - pc : pc - cand[i];
      end
    end

    for (int j = 0; j < 6; j++) begin
      if (gap[2*j+1] < gap[2*j]) begin
        l1_c[j] = cand[2*j+1];
        l1_d[j] = gap[2*j+1];
      end else begin
        l1_c[j] = cand[2*j];
        l1_d[j] = gap[2*j];
      end
    end

    for (int k = 0; k < 3; k++) begin
      if (l1_d[2*k+1] < l1_d[2*k]) begin
        l2_c[k] = l1_c[2*k+1];
        l2_d[k] = l1_d[2*k+1];
      end else begin
        l2_c[k] = l1_c[2*k];
        l2_d[k] = l1_d[2*k];
      end
    end

    if (l2_d[1] < l2_d[0]) begin
      l3_c = l2_c[1];
      l3_d = l2_d[1];
    end else begin
      l3_c = l2_c[0];
      l3_d = l2_d[0];
    end

    best = (l2_d[2] < l3_d) ? l2_c[2] : l3_c;
  end

  assign note_q = NOTE_OUT_W'(oct_x12) + NOTE_OUT_W'(best);
endmodule
